FILE: hdl/asmd_pkg.sv
// Shared types, constants and helpers for the ADC scan sequencer with motor detect.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package asmd_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int CHAN_COUNT_DEF  = 16;
    localparam int CAL_SAMPLES_DEF = 6;

    // Fixed field widths.
    localparam int CHAN_W    = 4;
    localparam int SAMPLE_W  = 16;
    localparam int SEL_W     = 8;
    localparam int DELTA_W   = 8;
    localparam int LEN_W     = 5;
    localparam int LIST_W    = 24;
    localparam int CAL_SUM_W = 19;
    localparam int LIST_ENTRIES = 6;
    localparam int QUEUE_DEPTH  = 2;

    // Reset values of the configuration and detect state.
    localparam logic [LEN_W-1:0]   SCAN_LEN_RESET = 5'd8;
    localparam logic [LIST_W-1:0]  CAL_LIST_RESET = 24'd0;
    localparam logic [DELTA_W-1:0] DELTA_RESET    = 8'd20;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCAN_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_CAL_LIST      = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_DELTA = 2'd2;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_CONV  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_READ  = 2'd3
    } req_e_t;

    // Motor-detect phases.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_STOP  = 2'd2,
        PH_RUN   = 2'd3
    } phase_e_t;

    // Classified request passed from the front to the back.
    typedef struct packed {
        req_e_t                req;
        logic [SAMPLE_W-1:0]   sample;
        logic                  sel_ok;
        logic [CHAN_W-1:0]     sel_idx;
        logic [DELTA_W-1:0]    delta;
    } cmd_t;

    // Configuration the back needs.
    typedef struct packed {
        logic [LEN_W-1:0]  scan_length;
        logic [LIST_W-1:0] cal_list;
    } cfg_t;

    // Calibration channel for a given calibration count; entries past the list read as 0.
    function automatic logic [CHAN_W-1:0] cal_chan(input logic [LIST_W-1:0] list,
                                                   input logic [3:0] count);
        logic [CHAN_W-1:0] ch;
        ch = '0;
        for (int i = 0; i < LIST_ENTRIES; i++) begin
            if (count == 4'(i)) begin
                ch = list[CHAN_W*i +: CHAN_W];
            end
        end
        return ch;
    endfunction

endpackage

FILE: hdl/asmd_front.sv
// Front end: holds the configuration registers and classifies incoming requests.
// Depends on asmd_pkg; feeds classified requests into asmd_queue.
module asmd_front
    import asmd_pkg::*;
#(
    parameter int CHAN_COUNT = CHAN_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [LIST_W-1:0]  cfg_data,
    output cmd_t               cmd,
    output logic               push_valid,
    input  logic               push_ready,
    output cfg_t               cfg
);

    logic [LEN_W-1:0]   scan_length_reg;
    logic [LIST_W-1:0]  cal_list_reg;
    logic [DELTA_W-1:0] default_delta_reg;

    logic [SEL_W-1:0]   sel;
    logic [DELTA_W-1:0] delta_in;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_length_reg   <= SCAN_LEN_RESET;
            cal_list_reg      <= CAL_LIST_RESET;
            default_delta_reg <= DELTA_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SCAN_LENGTH:   scan_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_CAL_LIST:      cal_list_reg      <= cfg_data;
                CFG_DEFAULT_DELTA: default_delta_reg <= cfg_data[DELTA_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.scan_length = scan_length_reg;
    assign cfg.cal_list    = cal_list_reg;

    // Classify the request: range check and default delta selection.
    assign sel      = s_tdata[SAMPLE_W +: SEL_W];
    assign delta_in = s_tdata[SAMPLE_W+SEL_W +: DELTA_W];

    always_comb begin
        cmd.req     = req_e_t'(s_tuser);
        cmd.sample  = s_tdata[SAMPLE_W-1:0];
        cmd.sel_ok  = (32'(sel) < 32'(CHAN_COUNT));
        cmd.sel_idx = sel[CHAN_W-1:0];
        cmd.delta   = (delta_in != '0) ? delta_in : default_delta_reg;
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

FILE: hdl/asmd_queue.sv
// Two-entry queue of classified requests between the front and the back.
// Depends on asmd_pkg for the request struct.
module asmd_queue
    import asmd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t push_cmd,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_cmd,
    output logic pop_valid,
    input  logic pop_ready
);

    cmd_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/asmd_back.sv
// Back end: calibration, round-robin scan, sample store and motor detect,
// with the registered result stage. Depends on asmd_pkg.
module asmd_back
    import asmd_pkg::*;
#(
    parameter int CHAN_COUNT  = CHAN_COUNT_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    localparam int IW = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
    localparam int CW = $clog2(CAL_SAMPLES + 1);
    // Division of the calibration sum by CAL_SAMPLES as a reciprocal multiply.
    localparam int SH = CAL_SUM_W + $clog2(CAL_SAMPLES);
    localparam logic [20:0] RECIP =
        21'(((64'd1 << SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    // Detect and scan state.
    logic [IW-1:0]        scan_index_reg, scan_index_next;
    phase_e_t             phase_reg, phase_next;
    logic [CHAN_W-1:0]    detect_chan_reg, detect_chan_next;
    logic [DELTA_W-1:0]   detect_delta_reg, detect_delta_next;
    logic                 found_reg, found_next;
    logic                 averaging_reg, averaging_next;
    logic [SAMPLE_W-1:0]  baseline_reg;
    logic                 base_pend_reg, base_pend_next;
    logic [CW-1:0]        cal_count_reg, cal_count_next;
    logic [CAL_SUM_W-1:0] cal_sum_reg, cal_sum_next;

    // Sample store with per-entry valid bits; an invalid entry reads as zero.
    logic [SAMPLE_W-1:0]   store_reg [CHAN_COUNT];
    logic [CHAN_COUNT-1:0] store_vld_reg;
    logic                  store_we;

    // Result stage.
    logic                m_tvalid_reg;
    logic                acc_reg, acc_next;
    logic [CHAN_W-1:0]   mux_reg, mux_next;
    logic                avg_out_reg, avg_out_next;
    logic [SAMPLE_W-1:0] rd_reg, rd_next;
    logic                found_out_reg;
    logic                cal_out_reg, cal_out_next;
    logic                busy_out_reg, busy_out_next;

    logic                 fire;
    logic                 cal_now;
    logic [IW:0]          scan_inc;
    logic [IW-1:0]        scan_adv;
    logic [CW-1:0]        cal_inc;
    logic [IW-1:0]        sel_i;
    logic [SAMPLE_W:0]    threshold;
    logic [39:0]          base_prod;

    assign fire      = cmd_valid && (!m_tvalid_reg || m_tready);
    assign cmd_ready = !m_tvalid_reg || m_tready;

    assign cal_now   = (32'(cal_count_reg) < 32'(CAL_SAMPLES));
    assign cal_inc   = cal_count_reg + CW'(1);
    assign sel_i     = cmd.sel_idx[IW-1:0];
    assign threshold = {1'b0, baseline_reg} + (SAMPLE_W+1)'(detect_delta_reg);

    // Next scan position: advance while below both the scan length and the channel count.
    always_comb begin
        scan_inc = {1'b0, scan_index_reg} + (IW+1)'(1);
        if ((32'(scan_inc) < 32'(cfg.scan_length)) && (32'(scan_inc) < 32'(CHAN_COUNT))) begin
            scan_adv = scan_inc[IW-1:0];
        end else begin
            scan_adv = '0;
        end
    end

    // Request execution and result computation.
    always_comb begin
        scan_index_next   = scan_index_reg;
        phase_next        = phase_reg;
        detect_chan_next  = detect_chan_reg;
        detect_delta_next = detect_delta_reg;
        found_next        = found_reg;
        averaging_next    = averaging_reg;
        cal_count_next    = cal_count_reg;
        cal_sum_next      = cal_sum_reg;
        base_pend_next    = 1'b0;
        store_we          = 1'b0;
        acc_next          = 1'b0;
        rd_next           = '0;

        if (fire) begin
            case (cmd.req)
                REQ_CONV: begin
                    acc_next = 1'b1;
                    if (cal_now) begin
                        cal_sum_next   = cal_sum_reg + CAL_SUM_W'(cmd.sample);
                        cal_count_next = cal_inc;
                        if (32'(cal_inc) >= 32'(CAL_SAMPLES)) begin
                            base_pend_next = 1'b1;
                        end
                    end else begin
                        case (phase_reg)
                            PH_START: begin
                                store_we       = 1'b1;
                                phase_next     = PH_RUN;
                                averaging_next = 1'b1;
                            end
                            PH_RUN: begin
                                if ({1'b0, cmd.sample} >= threshold) begin
                                    found_next      = 1'b1;
                                    phase_next      = PH_IDLE;
                                    averaging_next  = 1'b0;
                                    scan_index_next = scan_adv;
                                end
                            end
                            PH_STOP: begin
                                phase_next      = PH_IDLE;
                                averaging_next  = 1'b0;
                                scan_index_next = scan_adv;
                            end
                            default: begin
                                store_we        = 1'b1;
                                scan_index_next = scan_adv;
                            end
                        endcase
                    end
                end
                REQ_START: begin
                    if (phase_reg == PH_IDLE && cmd.sel_ok) begin
                        acc_next          = 1'b1;
                        detect_chan_next  = cmd.sel_idx;
                        detect_delta_next = cmd.delta;
                        phase_next        = PH_START;
                        found_next        = 1'b0;
                    end
                end
                REQ_STOP: begin
                    if (phase_reg != PH_IDLE) begin
                        acc_next   = 1'b1;
                        phase_next = PH_STOP;
                    end
                end
                default: begin
                    if (cmd.sel_ok) begin
                        acc_next = 1'b1;
                        rd_next  = store_vld_reg[sel_i] ? store_reg[sel_i] : '0;
                    end
                end
            endcase
        end

        // Converter control seen after this request.
        cal_out_next  = (32'(cal_count_next) < 32'(CAL_SAMPLES));
        avg_out_next  = cal_out_next || averaging_next;
        busy_out_next = (phase_next != PH_IDLE);
        if (cal_out_next) begin
            mux_next = cal_chan(cfg.cal_list, 4'(cal_count_next));
        end else if (averaging_next) begin
            mux_next = detect_chan_next;
        end else begin
            mux_next = CHAN_W'(scan_index_next);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_index_reg   <= '0;
            phase_reg        <= PH_IDLE;
            detect_chan_reg  <= '0;
            detect_delta_reg <= DELTA_RESET;
            found_reg        <= 1'b0;
            averaging_reg    <= 1'b0;
            baseline_reg     <= '0;
            base_pend_reg    <= 1'b0;
            cal_count_reg    <= '0;
            cal_sum_reg      <= '0;
            store_vld_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            scan_index_reg   <= scan_index_next;
            phase_reg        <= phase_next;
            detect_chan_reg  <= detect_chan_next;
            detect_delta_reg <= detect_delta_next;
            found_reg        <= found_next;
            averaging_reg    <= averaging_next;
            base_pend_reg    <= base_pend_next;
            cal_count_reg    <= cal_count_next;
            cal_sum_reg      <= cal_sum_next;
            if (base_pend_reg) begin
                baseline_reg <= base_prod[SH +: SAMPLE_W];
            end
            if (store_we) begin
                store_vld_reg[scan_index_reg] <= 1'b1;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Baseline is the calibration sum times the reciprocal, loaded while base_pend_reg is set after the last sample.
    assign base_prod = 40'(cal_sum_reg) * 40'(RECIP);

    // Store data and result payload.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[scan_index_reg] <= cmd.sample;
        end
        if (fire) begin
            acc_reg       <= acc_next;
            mux_reg       <= mux_next;
            avg_out_reg   <= avg_out_next;
            rd_reg        <= rd_next;
            found_out_reg <= found_next;
            cal_out_reg   <= cal_out_next;
            busy_out_reg  <= busy_out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, busy_out_reg, cal_out_reg, found_out_reg, rd_reg,
                       avg_out_reg, mux_reg, acc_reg};

endmodule

FILE: hdl/adc_scan_with_motor_detect_core.sv
// Top level of the ADC scan sequencer with motor detect.
// Depends on asmd_pkg, asmd_front, asmd_queue and asmd_back.
//
// Usage:
//   Input channel s_*: one request per item. s_tuser carries the request kind
//   (conversion done, detect start, detect stop, read stored sample); s_tdata
//   carries the conversion result, channel select and threshold delta.
//   Result channel m_*: exactly one result item per request, in order, giving
//   the accept flag, next converter channel and mode, read data and status.
//   Configuration channel cfg_*: register writes, taken in any cycle; write only
//   while no request is in flight.
// Throughput: one request per cycle while m_tready stays high; the two-entry queue
//   between the classifier and the execution stage absorbs short stalls.
// Reset (aresetn low, synchronous) clears the sample store, restarts calibration
//   and returns detection to idle; configuration returns to its defaults.
// When the receiver holds m_tready low, the result holds, the queue fills, and
//   s_tready drops once both queue entries are taken.
module adc_scan_with_motor_detect_core
    import asmd_pkg::*;
#(
    parameter int CHAN_COUNT  = CHAN_COUNT_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // sample[15:0], channel_sel[23:16], detect delta[31:24]
    input  logic [31:0]       s_tdata,
    // req_type[1:0]
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // accepted[0], mux_channel[4:1], averaging_mode[5], read_data[21:6],
    // motor_found[22], calibrating[23], detect_busy[24], zero fill [31:25]
    output logic [31:0]       m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [LIST_W-1:0] cfg_data
);

    cmd_t front_cmd, queue_cmd;
    cfg_t cfg;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;

    asmd_front #(
        .CHAN_COUNT(CHAN_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (front_cmd),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .cfg       (cfg)
    );

    asmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cmd  (front_cmd),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .pop_cmd   (queue_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready)
    );

    asmd_back #(
        .CHAN_COUNT (CHAN_COUNT),
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (queue_cmd),
        .cmd_valid(pop_valid),
        .cmd_ready(pop_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
